@@ sv/fuzzy_label_match_scorer_assert.svh @@
// Assertion macros for the fuzzy label match scorer checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FUZZY_LABEL_MATCH_SCORER_ASSERT_SVH
`define FUZZY_LABEL_MATCH_SCORER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define FLMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FLMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/flms_pkg.sv @@
// Shared types, codes and character helpers of the fuzzy label match scorer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flms_pkg;

  localparam int unsigned CHAR_W = 8;

  // Appends of bytes below this value are dropped
  localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'd32;

  // Request kinds on tuser
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LABEL  = 2'd3
  } opcode_e;

  // Score codes
  typedef enum logic [1:0] {
    SCORE_NONE    = 2'd0,
    SCORE_SCATTER = 2'd1,
    SCORE_WORD    = 2'd2,
    SCORE_PREFIX  = 2'd3
  } score_e;

  // Write request into the query store (address covers depths up to 256)
  typedef struct packed {
    logic              en;
    logic [7:0]        addr;
    logic [CHAR_W-1:0] data;
  } wr_req_t;

  // ASCII case fold: upper case letters map to lower case
  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // ASCII digit or letter
  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

`default_nettype wire

@@ sv/flms_query_store.sv @@
// Query character store with one comparator per position.
// Depends on flms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flms_query_store #(
  parameter int unsigned QUERY_MAX = 63
) (
  input  wire logic                         clk_i,
  input  wire flms_pkg::wr_req_t            wr_i,
  input  wire logic [flms_pkg::CHAR_W-1:0]  fc_i,   // folded label byte
  output logic      [QUERY_MAX-1:0]         eq_o    // position i equals fc_i
);

  localparam int unsigned IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

  // Folded query bytes; entries at or above the query length are never used
  logic [flms_pkg::CHAR_W-1:0] chars_q [QUERY_MAX];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      chars_q[wr_i.addr[IDX_W-1:0]] <= wr_i.data;
    end
  end

  // Compare every position against the incoming byte
  always_comb begin
    for (int i = 0; i < QUERY_MAX; i++) begin
      eq_o[i] = (chars_q[i] == fc_i);
    end
  end

endmodule

`default_nettype wire

@@ sv/fuzzy_label_match_scorer.sv @@
// Fuzzy label match scorer: takes one request per cycle on the slave stream. Query edits
// (append, delete last, clear) and label bytes share the stream, tuser telling them
// apart; the byte flagged by tlast ends a label and yields one score on the master
// stream, passing through the input register and then the result register, with the label's
// count since the last query edit. All query positions are compared against each label byte
// in parallel, which sets the rate at one request per cycle; the result register
// lets requests keep flowing while a score waits, and only a second pending score
// stalls the input. Depends on flms_pkg and flms_query_store.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_label_match_scorer #(
  parameter int unsigned QUERY_MAX   = 63,
  parameter int unsigned LABEL_COUNT = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  wire logic        s_axis_tlast,   // last_of_label
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata    // [1:0] score, [8:2] label_number
);

  localparam int unsigned LEN_W = $clog2(QUERY_MAX + 1);
  localparam int unsigned POS_W = $clog2(QUERY_MAX + 2);
  localparam int unsigned IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(LABEL_COUNT);

  // Input register
  logic                        in_v_q;
  flms_pkg::opcode_e           in_op_q;
  logic [flms_pkg::CHAR_W-1:0] in_ch_q;
  logic                        in_last_q;

  // Match state
  logic [LEN_W-1:0]     len_q,    len_d;
  logic [POS_W-1:0]     pos_q,    pos_d;
  logic                 prefix_q, prefix_d;
  logic [QUERY_MAX-1:0] wp_q,     wp_d;
  logic                 hit_q,    hit_d;
  logic                 prevna_q, prevna_d;
  logic [LEN_W-1:0]     sub_q,    sub_d;
  logic [CNT_W-1:0]     cnt_q,    cnt_d;

  // Result register
  logic                 out_v_q,  out_v_d;
  flms_pkg::score_e     score_q,  score_d;
  logic [6:0]           num_q,    num_d;

  logic                        need_out, adv;
  logic [flms_pkg::CHAR_W-1:0] fc;
  logic [QUERY_MAX-1:0]        eq;
  flms_pkg::wr_req_t           wr;

  // Per-byte next values of the label state
  logic [POS_W-1:0]     pos_n;
  logic                 prefix_n;
  logic [QUERY_MAX-1:0] wp_n;
  logic                 hit_n;
  logic [LEN_W-1:0]     sub_n;
  flms_pkg::score_e     score_n;

  // Handshake: an item leaves the input register unless it is a score and the
  // result register is full and not being drained
  assign need_out      = in_v_q && (in_op_q == flms_pkg::OP_LABEL) && in_last_q;
  assign adv           = in_v_q && (!need_out || !out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= flms_pkg::opcode_e'(s_axis_tuser);
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Query store and parallel compare
  assign fc      = flms_pkg::fold(in_ch_q);
  assign wr.en   = adv && (in_op_q == flms_pkg::OP_APPEND) &&
                   (in_ch_q >= flms_pkg::CTRL_LIMIT) && (len_q < LEN_W'(QUERY_MAX));
  assign wr.addr = 8'(len_q);
  assign wr.data = fc;

  flms_query_store #(
    .QUERY_MAX (QUERY_MAX)
  ) u_store (
    .clk_i (clk_i),
    .wr_i  (wr),
    .fc_i  (fc),
    .eq_o  (eq)
  );

  // Label byte update: prefix, word-start shift-and, subsequence, position
  always_comb begin
    logic prev;
    prefix_n = prefix_q &&
               !((pos_q < POS_W'(len_q)) && !eq[pos_q[IDX_W-1:0]]);
    for (int i = 0; i < QUERY_MAX; i++) begin
      prev    = (i == 0) ? prevna_q : wp_q[(i == 0) ? 0 : i - 1];
      wp_n[i] = prev && eq[i] && (LEN_W'(i) < len_q);
    end
    hit_n = hit_q || ((len_q != '0) && wp_n[IDX_W'(len_q - LEN_W'(1))]);
    sub_n = ((sub_q < len_q) && eq[sub_q[IDX_W-1:0]]) ? sub_q + LEN_W'(1) : sub_q;
    pos_n = (pos_q == POS_W'(QUERY_MAX + 1)) ? pos_q : pos_q + POS_W'(1);

    // Score from the state after this byte
    if (len_q == '0) begin
      score_n = flms_pkg::SCORE_SCATTER;
    end else if (pos_n < POS_W'(len_q)) begin
      score_n = flms_pkg::SCORE_NONE;
    end else if (prefix_n) begin
      score_n = flms_pkg::SCORE_PREFIX;
    end else if (hit_n) begin
      score_n = flms_pkg::SCORE_WORD;
    end else if (sub_n == len_q) begin
      score_n = flms_pkg::SCORE_SCATTER;
    end else begin
      score_n = flms_pkg::SCORE_NONE;
    end
  end

  // Next state per request kind
  always_comb begin
    logic edited;
    len_d    = len_q;
    pos_d    = pos_q;
    prefix_d = prefix_q;
    wp_d     = wp_q;
    hit_d    = hit_q;
    prevna_d = prevna_q;
    sub_d    = sub_q;
    cnt_d    = cnt_q;
    score_d  = score_q;
    num_d    = num_q;
    out_v_d  = out_v_q && !m_axis_tready;
    edited   = 1'b0;

    if (adv) begin
      unique case (in_op_q)
        flms_pkg::OP_APPEND: begin
          if (wr.en) begin
            len_d  = len_q + LEN_W'(1);
            edited = 1'b1;
          end
        end
        flms_pkg::OP_DELETE: begin
          if (len_q != '0) begin
            len_d  = len_q - LEN_W'(1);
            edited = 1'b1;
          end
        end
        flms_pkg::OP_CLEAR: begin
          len_d  = '0;
          edited = 1'b1;
        end
        flms_pkg::OP_LABEL: begin
          if (in_last_q) begin
            // Emit the score and start a fresh label
            out_v_d  = 1'b1;
            score_d  = score_n;
            num_d    = 7'(cnt_q);
            cnt_d    = (cnt_q == CNT_W'(LABEL_COUNT - 1)) ? '0 : cnt_q + CNT_W'(1);
            pos_d    = '0;
            prefix_d = 1'b1;
            wp_d     = '0;
            hit_d    = 1'b0;
            prevna_d = 1'b0;
            sub_d    = '0;
          end else begin
            pos_d    = pos_n;
            prefix_d = prefix_n;
            wp_d     = wp_n;
            hit_d    = hit_n;
            prevna_d = !flms_pkg::is_alnum(in_ch_q);
            sub_d    = sub_n;
          end
        end
        default: ;
      endcase
    end

    // An effective edit drops the label in progress and restarts the count
    if (edited) begin
      pos_d    = '0;
      prefix_d = 1'b1;
      wp_d     = '0;
      hit_d    = 1'b0;
      prevna_d = 1'b0;
      sub_d    = '0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pos_q    <= '0;
      prefix_q <= 1'b1;
      wp_q     <= '0;
      hit_q    <= 1'b0;
      prevna_q <= 1'b0;
      sub_q    <= '0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      prefix_q <= prefix_d;
      wp_q     <= wp_d;
      hit_q    <= hit_d;
      prevna_q <= prevna_d;
      sub_q    <= sub_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    num_q   <= num_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, num_q, score_q};

endmodule

`default_nettype wire

@@ sv/flms_checker.sv @@
// Port-level checks for the fuzzy label match scorer, bound to its top level.
// Depends on flms_pkg and fuzzy_label_match_scorer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fuzzy_label_match_scorer_assert.svh"

module flms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  logic label_end_req;
  assign label_end_req = s_axis_tvalid && s_axis_tready && s_axis_tlast &&
                         (s_axis_tuser == flms_pkg::OP_LABEL);

  // A clock edge in reset leaves no score shown
  `FLMS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid, "score valid in reset")

  // With the result register empty the input never stalls
  `FLMS_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

  // A new score always follows an accepted label end request
  `FLMS_ASSERT(a_score_source, $rose(m_axis_tvalid) |-> $past(label_end_req, 2), "score without label end")

  // A stalled score stays put
  `FLMS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled score changed")

endmodule

bind fuzzy_label_match_scorer flms_checker u_flms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb_fuzzy_label_match_scorer.sv @@
// Self-checking testbench for the fuzzy label match scorer: directed and random
// query edits and label streams, scored by an in-bench predictor. Needs flms_pkg
// and the fuzzy_label_match_scorer RTL.
`timescale 1ns / 1ps

module tb_fuzzy_label_match_scorer;
  import flms_pkg::*;

  localparam int QUERY_DEPTH  = 63;
  localparam int LABEL_WRAP   = 128;
  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] ch;
    logic       last;
  } scorer_req_t;

  typedef struct packed {
    score_e     score;
    logic [6:0] number;
  } score_rec_t;

  typedef enum int {
    SHAPE_PREFIX,
    SHAPE_WORD,
    SHAPE_SCATTER,
    SHAPE_NEAR,
    SHAPE_SHORT,
    SHAPE_NOISE
  } label_shape_e;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RARE_STALL
  } rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] char_code
  logic [1:0]  s_axis_tuser  = 2'b00;  // [1:0] opcode
  logic        s_axis_tlast  = 1'b0;   // last_of_label
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [1:0] score, [8:2] label_number

  fuzzy_label_match_scorer #(
    .QUERY_MAX  (QUERY_DEPTH),
    .LABEL_COUNT(LABEL_WRAP)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Score predictor state
  // ---------------------------------------------------------------------------
  logic [7:0]             q_text [QUERY_DEPTH];
  int                     q_len;
  int                     lbl_pos;
  int                     subseq_cnt;
  logic                   prefix_ok;
  logic                   word_hit;
  logic                   prev_sep;
  logic [QUERY_DEPTH-1:0] word_vec;
  logic [6:0]             label_cnt;
  score_rec_t             expected_scores[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit started        = 1'b0;
  bit req_taken      = 1'b0;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  task automatic drop_label_state();
    lbl_pos    = 0;
    prefix_ok  = 1'b1;
    word_vec   = '0;
    word_hit   = 1'b0;
    prev_sep   = 1'b0;
    subseq_cnt = 0;
  endtask

  task automatic query_changed();
    drop_label_state();
    label_cnt = '0;
  endtask

  // Advance the predictor by one accepted request; a closing label byte queues a score
  task automatic score_request(input scorer_req_t req);
    logic [7:0] fc;
    score_rec_t rec;
    case (req.op)
      OP_APPEND: begin
        if (req.ch >= CTRL_LIMIT && q_len < QUERY_DEPTH) begin
          q_text[q_len] = req.ch;
          q_len++;
          query_changed();
        end
      end
      OP_DELETE: begin
        if (q_len > 0) begin
          q_len--;
          query_changed();
        end
      end
      OP_CLEAR: begin
        q_len = 0;
        query_changed();
      end
      default: begin
        fc = lower_ascii(req.ch);
        if (lbl_pos < q_len && lower_ascii(q_text[lbl_pos]) != fc) begin
          prefix_ok = 1'b0;
        end
        // shift-and step, highest position first so each bit sees the old one below
        for (int k = q_len - 1; k >= 1; k--) begin
          word_vec[k] = word_vec[k-1] && (lower_ascii(q_text[k]) == fc);
        end
        if (q_len > 0) begin
          word_vec[0] = prev_sep && (lower_ascii(q_text[0]) == fc);
          if (word_vec[q_len-1]) begin
            word_hit = 1'b1;
          end
        end
        if (subseq_cnt < q_len && lower_ascii(q_text[subseq_cnt]) == fc) begin
          subseq_cnt++;
        end
        prev_sep = !is_word_char(req.ch);
        if (lbl_pos < QUERY_DEPTH + 1) begin
          lbl_pos++;
        end
        if (req.last) begin
          if (q_len == 0) begin
            rec.score = SCORE_SCATTER;
          end else if (lbl_pos < q_len) begin
            rec.score = SCORE_NONE;
          end else if (prefix_ok) begin
            rec.score = SCORE_PREFIX;
          end else if (word_hit) begin
            rec.score = SCORE_WORD;
          end else if (subseq_cnt == q_len) begin
            rec.score = SCORE_SCATTER;
          end else begin
            rec.score = SCORE_NONE;
          end
          rec.number = label_cnt;
          expected_scores.push_back(rec);
          label_cnt = label_cnt + 7'd1;
          drop_label_state();
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  scorer_req_t pending_reqs[$];
  logic [7:0]  gen_query[$];   // query text as the block should hold it
  logic [7:0]  label_buf[$];
  int          rand_count;

  task automatic queue_req(input opcode_e op, input logic [7:0] ch, input logic last);
    scorer_req_t r;
    r.op   = op;
    r.ch   = ch;
    r.last = last;
    pending_reqs.push_back(r);
    rand_count++;
    case (op)
      OP_APPEND: begin
        if (ch >= CTRL_LIMIT && gen_query.size() < QUERY_DEPTH) begin
          gen_query.push_back(ch);
        end
      end
      OP_DELETE: begin
        if (gen_query.size() > 0) begin
          void'(gen_query.pop_back());
        end
      end
      OP_CLEAR: begin
        gen_query.delete();
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic [7:0] noise_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h2D;
      2:       return 8'h5F;
      3:       return 8'h2E;
      4:       return 8'h2F;
      default: return 8'($urandom_range(0, 47));
    endcase
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // Mostly letters and digits, some printable punctuation, the rest any byte from 32 to 255
  function automatic logic [7:0] pick_query_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return pick_alnum();
    end
    if (r < 92) begin
      case ($urandom_range(0, 3))
        0:       return 8'h20;
        1:       return 8'h2D;
        2:       return 8'h5F;
        default: return 8'h2E;
      endcase
    end
    return 8'($urandom_range(32, 255));
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && rand_bit()) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic flush_label();
    for (int k = 0; k < label_buf.size(); k++) begin
      queue_req(OP_LABEL, label_buf[k], k == label_buf.size() - 1);
    end
    label_buf.delete();
  endtask

  // Label built around the current query so that each score level gets reached
  task automatic build_label(input label_shape_e shape);
    int n;
    int cut;
    int bad;
    n = gen_query.size();
    case (shape)
      SHAPE_PREFIX: begin
        for (int k = 0; k < n; k++) label_buf.push_back(vary_case(gen_query[k]));
        repeat ($urandom_range(0, 4)) label_buf.push_back(noise_char());
      end
      SHAPE_WORD: begin
        repeat ($urandom_range(1, 4)) label_buf.push_back(pick_alnum());
        label_buf.push_back(pick_separator());
        for (int k = 0; k < n; k++) label_buf.push_back(vary_case(gen_query[k]));
        repeat ($urandom_range(0, 3)) label_buf.push_back(noise_char());
      end
      SHAPE_SCATTER: begin
        for (int k = 0; k < n; k++) begin
          repeat ($urandom_range(0, 2)) label_buf.push_back(pick_query_char());
          label_buf.push_back(vary_case(gen_query[k]));
        end
      end
      SHAPE_NEAR: begin
        bad = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if ($urandom_range(0, 1) == 1) label_buf.push_back(pick_separator());
        for (int k = 0; k < n; k++) begin
          label_buf.push_back((k == bad) ? noise_char() : vary_case(gen_query[k]));
        end
      end
      SHAPE_SHORT: begin
        cut = (n > 1) ? $urandom_range(1, n - 1) : 0;
        for (int k = 0; k < cut; k++) label_buf.push_back(vary_case(gen_query[k]));
      end
      default: begin
        repeat ($urandom_range(1, 10)) label_buf.push_back(noise_char());
      end
    endcase
    if (label_buf.size() == 0) begin
      label_buf.push_back(noise_char());
    end
    flush_label();
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check scores, feed accepted requests to the predictor, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_streams
    score_rec_t  want;
    scorer_req_t got_req;
    logic        any_taken;
    if (rst_ni) begin
      any_taken = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        any_taken = 1'b1;
        if (expected_scores.size() == 0) begin
          report_mismatch($sformatf("score word %h with no label pending", m_axis_tdata));
        end else begin
          want = expected_scores.pop_front();
          if (m_axis_tdata[1:0] !== want.score) begin
            report_mismatch($sformatf("label %0d: score %0d, predicted %0d",
                                      want.number, m_axis_tdata[1:0], want.score));
          end
          if (m_axis_tdata[8:2] !== want.number) begin
            report_mismatch($sformatf("label number %0d, predicted %0d",
                                      m_axis_tdata[8:2], want.number));
          end
          if (m_axis_tdata[15:9] !== '0) begin
            report_mismatch($sformatf("padding bits %h not zero", m_axis_tdata[15:9]));
          end
        end
      end
      req_taken = s_axis_tvalid && s_axis_tready;
      if (req_taken) begin
        any_taken    = 1'b1;
        got_req.op   = opcode_e'(s_axis_tuser);
        got_req.ch   = s_axis_tdata;
        got_req.last = s_axis_tlast;
        score_request(got_req);
      end
      // watchdog: cycles with no handshake on either stream
      idle_cycles = any_taken ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fuzzy_label_match_scorer: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 0;

  always @(negedge clk_i) begin : drive_requests
    scorer_req_t nxt;
    logic        go;
    if (started && !(s_axis_tvalid && !req_taken)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        go  = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long run with no gaps at all
          if ($urandom_range(0, 7) == 0) begin
            gap_left   = 0;
            burst_left = $urandom_range(40, 120);
          end else begin
            gap_left   = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
          end
        end
      end
      s_axis_tvalid <= go;
      if (go) begin
        s_axis_tdata <= nxt.ch;
        s_axis_tuser <= nxt.op;
        s_axis_tlast <= nxt.last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Score receiver: stall patterns that change over time, plus long hold-offs
  // ---------------------------------------------------------------------------
  int       rx_cycle  = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode   = RX_OPEN;

  always @(negedge clk_i) begin : drive_result_ready
    logic rdy;
    if (started) begin
      rx_cycle++;
      if (rx_cycle == 900 || rx_cycle == 2500) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, RX_RARE_STALL));
          mode_left = $urandom_range(40, 200);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = rand_bit();
          RX_SPARSE: rdy = (rx_cycle % 4) == 0;
          default:   rdy = $urandom_range(0, 9) != 0;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int r;
    int fills;
    int wraps;
    q_len = 0;
    query_changed();
    fills = 0;
    wraps = 0;

    // Directed: empty query, control and full-range bytes, each score level
    queue_req(OP_LABEL, 8'h00, 1'b1);   // empty query scores scattered, number 0
    queue_req(OP_LABEL, 8'hFF, 1'b1);   // number 1
    queue_req(OP_APPEND, 8'h1F, 1'b1);  // control byte dropped, last flag ignored
    queue_req(OP_DELETE, 8'h41, 1'b0);  // delete on empty query dropped
    queue_req(OP_APPEND, 8'h41, 1'b0);  // "A"
    queue_req(OP_APPEND, 8'h62, 1'b0);  // "Ab"
    queue_req(OP_LABEL, 8'h61, 1'b0);   // "aB": prefix, case folded
    queue_req(OP_LABEL, 8'h42, 1'b1);
    queue_req(OP_LABEL, 8'h78, 1'b0);   // "x-AB": word start
    queue_req(OP_LABEL, 8'h2D, 1'b0);
    queue_req(OP_LABEL, 8'h41, 1'b0);
    queue_req(OP_LABEL, 8'h42, 1'b1);
    queue_req(OP_LABEL, 8'h61, 1'b0);   // "axb": scattered
    queue_req(OP_LABEL, 8'h78, 1'b0);
    queue_req(OP_LABEL, 8'h62, 1'b1);
    queue_req(OP_LABEL, 8'h61, 1'b1);   // shorter than the query
    queue_req(OP_LABEL, 8'h62, 1'b0);   // "ba": out of order
    queue_req(OP_LABEL, 8'h61, 1'b1);
    queue_req(OP_DELETE, 8'h00, 1'b1);  // "A"
    queue_req(OP_APPEND, 8'hFF, 1'b0);  // "A\xff"
    queue_req(OP_APPEND, 8'h20, 1'b0);  // "A\xff "
    queue_req(OP_LABEL, 8'h2E, 1'b0);   // ".a\xff ": word start after a dot
    queue_req(OP_LABEL, 8'h61, 1'b0);
    queue_req(OP_LABEL, 8'hFF, 1'b0);
    queue_req(OP_LABEL, 8'h20, 1'b1);
    queue_req(OP_CLEAR, 8'h7F, 1'b1);

    // Random: mostly fresh queries followed by shaped labels, plus noise
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 3) == 0 && gen_query.size() > 0) begin
          repeat ($urandom_range(1, 2)) queue_req(OP_DELETE, noise_char(), rand_bit());
        end else begin
          queue_req(OP_CLEAR, noise_char(), rand_bit());
          repeat ($urandom_range(0, 6)) queue_req(OP_APPEND, pick_query_char(), rand_bit());
        end
        repeat ($urandom_range(2, 6)) build_label(label_shape_e'($urandom_range(0, SHAPE_NOISE)));
      end else if (r < 68) begin
        repeat ($urandom_range(1, 4)) build_label(label_shape_e'($urandom_range(0, SHAPE_NOISE)));
      end else if (r < 82) begin
        repeat ($urandom_range(1, 4)) begin
          queue_req(opcode_e'($urandom_range(0, 2)), noise_char(), rand_bit());
        end
      end else if (r < 92) begin
        // broken labels: stray last flags and edits in the middle of a label
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 4) == 0) begin
            queue_req(opcode_e'($urandom_range(0, 3)), noise_char(), rand_bit());
          end else begin
            queue_req(OP_LABEL,
                      (gen_query.size() > 0) ?
                        vary_case(gen_query[$urandom_range(0, gen_query.size() - 1)]) :
                        noise_char(),
                      $urandom_range(0, 5) == 0);
          end
        end
      end else if (r < 96 && fills < 3) begin
        // full query, appends past the end, labels longer than the query
        fills++;
        queue_req(OP_CLEAR, noise_char(), 1'b0);
        while (gen_query.size() < QUERY_DEPTH) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_req(OP_APPEND, 8'($urandom_range(0, 31)), rand_bit());
          end else begin
            queue_req(OP_APPEND, pick_query_char(), 1'b0);
          end
        end
        repeat (2) queue_req(OP_APPEND, pick_query_char(), rand_bit());
        build_label(SHAPE_PREFIX);
        build_label(SHAPE_WORD);
        build_label(SHAPE_SCATTER);
        build_label(SHAPE_NEAR);
        build_label(SHAPE_SHORT);
      end else if (wraps == 0) begin
        // run the label counter past its wrap
        wraps++;
        queue_req(OP_CLEAR, noise_char(), 1'b0);
        repeat (LABEL_WRAP + 5) queue_req(OP_LABEL, noise_char(), 1'b1);
      end else begin
        build_label(SHAPE_NOISE);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);
    started = 1'b1;

    // drain: every request taken and every score seen, then a quiet tail
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_scores.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("fuzzy_label_match_scorer: match");
    end else begin
      $display("fuzzy_label_match_scorer: mismatch");
    end
    $finish;
  end

endmodule
